### rtl/sorted_key_table_macros.svh
// Assertion macros for the sorted key table checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SKT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// No dependencies; imported by the controller, datapath, top level and checker.
package skt_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 11;
  localparam int TAG_W    = 8;
  localparam int POS_W    = 3;
  localparam int OCNT_W   = 4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } skt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_stop;
  } skt_stat_t;

endpackage

### rtl/skt_ctrl.sv
// Sequencer for the sorted key table: accept, scan, update, result handoff.
// Depends on skt_pkg; drives skt_datapath through skt_cmd_t.
module skt_ctrl
  import skt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  skt_stat_t stat,
  output skt_cmd_t  cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_stop) begin
          state_next = S_UPDATE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_UPDATE: begin
        // result register must be free or draining this cycle
        if (!out_valid || !out_stall) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/skt_datapath.sv
// Entry storage, scan compare, shift cells and result register of the table.
// Depends on skt_pkg; sequenced by skt_ctrl.
module skt_datapath
  import skt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  skt_cmd_t          cmd,
  output skt_stat_t         stat,
  input  logic              mode,
  input  logic [KEY_W-1:0]  time_key,
  input  logic [TAG_W-1:0]  client_tag,
  output status_t           status,
  output logic [POS_W-1:0]  position,
  output logic [OCNT_W-1:0] entry_count,
  output logic              is_empty,
  output logic              is_full
);

  logic [KEY_W-1:0] key_store [CAPACITY];
  logic [TAG_W-1:0] tag_store [CAPACITY];
  logic [KEY_W-1:0] key_next  [CAPACITY];
  logic [TAG_W-1:0] tag_next  [CAPACITY];
  logic [CNT_W-1:0] count, count_next;

  logic             op_mode;
  logic [KEY_W-1:0] op_key;
  logic [TAG_W-1:0] op_tag;
  logic [CNT_W-1:0] scan_idx;

  logic [KEY_W-1:0] rd_key;
  logic             scan_end, hit, table_full, do_ins, do_del;
  status_t          res_status_next;

  // scan compare: one entry per cycle, the table is sorted so the first
  // entry not below the key is both the match point and the insert point
  assign rd_key     = key_store[scan_idx[IDX_W-1:0]];
  assign scan_end   = (scan_idx == count);
  assign hit        = !scan_end && (rd_key == op_key);
  assign table_full = (count == CNT_W'(CAPACITY));
  assign stat.scan_stop = scan_end || (rd_key >= op_key);

  assign do_ins = cmd.commit && (op_mode == MODE_INSERT) && !hit && !table_full;
  assign do_del = cmd.commit && (op_mode == MODE_DELETE) && hit;

  // command capture and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_key   <= time_key;
      op_tag   <= client_tag;
      scan_idx <= '0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // one shift cell per entry: open a gap at the scan point or close one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key, succ_key;
    logic [TAG_W-1:0] prev_tag, succ_tag;

    if (i > 0) begin : g_prev
      assign prev_key = key_store[i-1];
      assign prev_tag = tag_store[i-1];
    end else begin : g_first
      assign prev_key = key_store[i];
      assign prev_tag = tag_store[i];
    end

    if (i < CAPACITY - 1) begin : g_succ
      assign succ_key = key_store[i+1];
      assign succ_tag = tag_store[i+1];
    end else begin : g_last
      assign succ_key = key_store[i];
      assign succ_tag = tag_store[i];
    end

    always_comb begin
      key_next[i] = key_store[i];
      tag_next[i] = tag_store[i];
      if (do_ins) begin
        if (scan_idx == CNT_W'(i)) begin
          key_next[i] = op_key;
          tag_next[i] = op_tag;
        end else if (scan_idx < CNT_W'(i)) begin
          key_next[i] = prev_key;
          tag_next[i] = prev_tag;
        end
      end else if (do_del) begin
        if (scan_idx <= CNT_W'(i)) begin
          key_next[i] = succ_key;
          tag_next[i] = succ_tag;
        end
      end
    end

    always_ff @(posedge clk) begin
      key_store[i] <= key_next[i];
      tag_store[i] <= tag_next[i];
    end
  end

  // entry count
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_del) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result status; duplicate check takes priority over full
  always_comb begin
    if (op_mode == MODE_INSERT) begin
      if (hit) begin
        res_status_next = ST_DUP;
      end else if (table_full) begin
        res_status_next = ST_FULL;
      end else begin
        res_status_next = ST_DONE;
      end
    end else begin
      res_status_next = hit ? ST_DONE : ST_MISSING;
    end
  end

  // result register, loaded on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= res_status_next;
      position    <= (res_status_next == ST_DONE) ? POS_W'(scan_idx) : '0;
      entry_count <= OCNT_W'(count_next);
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == CNT_W'(CAPACITY));
    end
  end

endmodule

### rtl/sorted_key_table.sv
// Sorted key table: up to CAPACITY (key, tag) entries in ascending key order.
// One command at a time: the scan checks one entry per cycle up to the key's
// sorted position p (0..count), then the shift and the result are committed
// together, held back while a stalled result still occupies the result register.
// The next command is taken only after the commit; all entries shift at once.
// Synchronous reset empties the table; entry contents are not cleared.
module sorted_key_table
  import skt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [KEY_W-1:0]  time_key,
  input  logic [TAG_W-1:0]  client_tag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [POS_W-1:0]  position,
  output logic [OCNT_W-1:0] entry_count,
  output logic              is_empty,
  output logic              is_full
);

  skt_cmd_t  cmd;
  skt_stat_t stat;
  status_t   res_status;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  skt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .time_key    (time_key),
    .client_tag  (client_tag),
    .status      (res_status),
    .position    (position),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  assign status = res_status;

endmodule

### rtl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_macros.svh.
`include "sorted_key_table_macros.svh"

module skt_checker
  import skt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              mode,
  input logic [KEY_W-1:0]  time_key,
  input logic [TAG_W-1:0]  client_tag,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [POS_W-1:0]  position,
  input logic [OCNT_W-1:0] entry_count,
  input logic              is_empty,
  input logic              is_full
);

  // a stalled result stays offered
  `SKT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a stalled command stays offered with the same fields
  `SKT_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable({mode, time_key, client_tag}), "stalled command changed")

  // one command in flight: input stalls right after a transfer
  `SKT_ASSERT_NEXT(a_one_cmd, clk, rst, in_valid && !in_stall, in_stall, "second command taken during work")

  // failed commands report position zero
  `SKT_ASSERT_IMP(a_fail_pos, clk, rst, out_valid && (status != 2'(ST_DONE)), position == '0, "nonzero position on failure")

  // empty flag agrees with the count; empty and full are never both set
  `SKT_ASSERT_IMP(a_flags, clk, rst, out_valid, (is_empty == (entry_count == '0)) && !(is_empty && is_full), "empty/full flags disagree with count")

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);
